>>> hdl/otdg_pkg.sv
// Package for the overlapped tile descriptor generator.
// Holds the register indexes, pixel format codes, sequencer states and shared structs.
// No dependencies.
package otdg_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INPUT_BASE     = 4'd0,
        REG_OUTPUT_BASE    = 4'd1,
        REG_IMAGE_WIDTH    = 4'd2,
        REG_IMAGE_HEIGHT   = 4'd3,
        REG_PIXEL_FORMAT   = 4'd4,
        REG_OVERLAP_PIXELS = 4'd5,
        REG_TILE_WIDTH     = 4'd6,
        REG_TILE_HEIGHT    = 4'd7
    } otdg_reg_index_t;

    // Pixel format codes; anything above FMT_FLOAT4 is invalid
    localparam logic [2:0] FMT_HALF3  = 3'd0;
    localparam logic [2:0] FMT_HALF4  = 3'd1;
    localparam logic [2:0] FMT_FLOAT3 = 3'd2;
    localparam logic [2:0] FMT_FLOAT4 = 3'd3;

    // Operand widths of the shared multiply-accumulate unit
    localparam int OP_A_W = 17;
    localparam int OP_B_W = 21;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIDE,
        ST_IN_ROW,
        ST_IN_COL,
        ST_OUT_ROW,
        ST_OUT_COL,
        ST_DONE
    } otdg_state_t;

    // Clamped geometry from the register file
    typedef struct packed {
        logic [15:0] image_w;
        logic [15:0] image_h;
        logic [15:0] overlap;
        logic [15:0] tile_w;
        logic [15:0] tile_h;
        logic [2:0]  format;
    } otdg_geom_t;

    // Control of the multiply-accumulate unit
    typedef struct packed {
        logic enable;
        logic start;
    } otdg_mac_ctl_t;

    // Bytes per pixel for a valid format code
    function automatic logic [4:0] pixel_bytes(input logic [1:0] fmt);
        logic [4:0] bytes;
        case (fmt)
            FMT_HALF3[1:0]:  bytes = 5'd6;
            FMT_HALF4[1:0]:  bytes = 5'd8;
            FMT_FLOAT3[1:0]: bytes = 5'd12;
            default:         bytes = 5'd16;
        endcase
        return bytes;
    endfunction

endpackage

>>> hdl/overlapped_tile_descriptor_generator.sv
// Overlapped tile descriptor generator, top level.
// A new request is taken only in the idle state, after the previous descriptor has been handed off.
// Each descriptor takes five passes through the shared
// multiply-accumulate unit (stride, two per address) plus accept and hand-off.
// Reset (aresetn, synchronous, active low) restores register defaults and the first tile.
// Depends on otdg_pkg, otdg_regs and otdg_mac.
module overlapped_tile_descriptor_generator
    import otdg_pkg::*;
#(
    parameter int ADDRESS_BITS    = 48,
    parameter int DIMENSION_LIMIT = 16384
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ADDRESS_BITS-1:0] cfg_data,
    // request
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_restart,
    // descriptor
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ADDRESS_BITS-1:0] m_in_address,
    output logic [15:0]             m_in_width,
    output logic [15:0]             m_in_height,
    output logic [ADDRESS_BITS-1:0] m_out_address,
    output logic [14:0]             m_out_width,
    output logic [14:0]             m_out_height,
    output logic [18:0]             m_row_stride_bytes,
    output logic [14:0]             m_offset_x,
    output logic [14:0]             m_offset_y,
    output logic                    m_last_tile,
    output logic                    m_setting_error
);

    logic [ADDRESS_BITS-1:0] input_base;
    logic [ADDRESS_BITS-1:0] output_base;
    otdg_geom_t              geom;

    otdg_state_t state_reg;
    otdg_state_t state_next;

    logic [14:0] col_reg;
    logic [14:0] row_reg;
    logic [14:0] col_next;
    logic [14:0] row_next;
    logic [19:0] stride_reg;
    logic [ADDRESS_BITS-1:0] in_addr_reg;

    logic                    m_valid_reg;
    logic [ADDRESS_BITS-1:0] in_address_reg;
    logic [15:0]             in_width_reg;
    logic [15:0]             in_height_reg;
    logic [ADDRESS_BITS-1:0] out_address_reg;
    logic [14:0]             out_width_reg;
    logic [14:0]             out_height_reg;
    logic [18:0]             stride_out_reg;
    logic [14:0]             offset_x_reg;
    logic [14:0]             offset_y_reg;
    logic                    last_tile_reg;
    logic                    setting_error_reg;

    otdg_mac_ctl_t            mac_ctl;
    logic signed [OP_A_W-1:0] mac_a;
    logic signed [OP_B_W-1:0] mac_b;
    logic [ADDRESS_BITS-1:0]  mac_base;
    logic [ADDRESS_BITS-1:0]  mac_acc;

    logic        s_xfer;
    logic        load_out;
    logic        capture_stride;
    logic        capture_in_addr;

    logic [4:0]  px_bytes;
    logic        err;
    logic [15:0] offx;
    logic [15:0] offy;
    logic [15:0] availw;
    logic [15:0] availh;
    logic [16:0] ov_tw;
    logic [16:0] ov_th;
    logic [16:0] in_w_min;
    logic [16:0] in_h_min;
    logic [16:0] in_w_sum;
    logic [16:0] in_h_sum;
    logic [15:0] out_w;
    logic [15:0] out_h;
    logic signed [OP_A_W-1:0] inx;
    logic signed [OP_A_W-1:0] iny;
    logic [16:0] col_step;
    logic [16:0] row_step;
    logic        last;

    otdg_regs #(
        .ADDRESS_BITS   (ADDRESS_BITS),
        .DIMENSION_LIMIT(DIMENSION_LIMIT)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (cfg_valid && cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .input_base (input_base),
        .output_base(output_base),
        .geom       (geom)
    );

    otdg_mac #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_mac (
        .aclk(aclk),
        .ctl (mac_ctl),
        .op_a(mac_a),
        .op_b(mac_b),
        .base(mac_base),
        .acc (mac_acc)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Tile geometry from the current position
    assign px_bytes = pixel_bytes(geom.format[1:0]);
    assign err      = (geom.format > FMT_FLOAT4) || (geom.overlap > geom.tile_w)
                      || (geom.overlap > geom.tile_h);
    assign offx     = (col_reg == 15'd0) ? 16'd0 : geom.overlap;
    assign offy     = (row_reg == 15'd0) ? 16'd0 : geom.overlap;
    assign availw   = ({1'b0, col_reg} < geom.image_w) ? geom.image_w - {1'b0, col_reg} : 16'd0;
    assign availh   = ({1'b0, row_reg} < geom.image_h) ? geom.image_h - {1'b0, row_reg} : 16'd0;
    assign ov_tw    = {1'b0, geom.overlap} + {1'b0, geom.tile_w};
    assign ov_th    = {1'b0, geom.overlap} + {1'b0, geom.tile_h};
    assign in_w_min = ({1'b0, availw} < ov_tw) ? {1'b0, availw} : ov_tw;
    assign in_h_min = ({1'b0, availh} < ov_th) ? {1'b0, availh} : ov_th;
    assign in_w_sum = in_w_min + {1'b0, offx};
    assign in_h_sum = in_h_min + {1'b0, offy};
    assign out_w    = (availw < geom.tile_w) ? availw : geom.tile_w;
    assign out_h    = (availh < geom.tile_h) ? availh : geom.tile_h;
    assign inx      = $signed({2'b00, col_reg}) - $signed({1'b0, offx});
    assign iny      = $signed({2'b00, row_reg}) - $signed({1'b0, offy});

    // Walk advance: next column, else next row, else wrap
    assign col_step = {2'b00, col_reg} + {1'b0, geom.tile_w};
    assign row_step = {2'b00, row_reg} + {1'b0, geom.tile_h};
    always_comb begin
        col_next = col_step[14:0];
        row_next = row_reg;
        last     = 1'b0;
        if (col_step >= {1'b0, geom.image_w}) begin
            col_next = 15'd0;
            row_next = row_step[14:0];
            if (row_step >= {1'b0, geom.image_h}) begin
                row_next = 15'd0;
                last     = 1'b1;
            end
        end
    end

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_xfer) state_next = ST_STRIDE;
            ST_STRIDE:  state_next = ST_IN_ROW;
            ST_IN_ROW:  state_next = ST_IN_COL;
            ST_IN_COL:  state_next = ST_OUT_ROW;
            ST_OUT_ROW: state_next = ST_OUT_COL;
            ST_OUT_COL: state_next = ST_DONE;
            ST_DONE:    if (load_out) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer: unit operands and capture strobes
    always_comb begin
        mac_ctl         = '0;
        mac_a           = '0;
        mac_b           = '0;
        mac_base        = '0;
        capture_stride  = 1'b0;
        capture_in_addr = 1'b0;
        case (state_reg)
            ST_STRIDE: begin
                mac_ctl = '{enable: 1'b1, start: 1'b1};
                mac_a   = $signed({1'b0, geom.image_w});
                mac_b   = $signed({16'd0, px_bytes});
            end
            ST_IN_ROW: begin
                mac_ctl        = '{enable: 1'b1, start: 1'b1};
                mac_a          = iny;
                mac_b          = $signed({1'b0, mac_acc[19:0]});
                mac_base       = input_base;
                capture_stride = 1'b1;
            end
            ST_IN_COL: begin
                mac_ctl = '{enable: 1'b1, start: 1'b0};
                mac_a   = inx;
                mac_b   = $signed({16'd0, px_bytes});
            end
            ST_OUT_ROW: begin
                mac_ctl         = '{enable: 1'b1, start: 1'b1};
                mac_a           = $signed({2'b00, row_reg});
                mac_b           = $signed({1'b0, stride_reg});
                mac_base        = output_base;
                capture_in_addr = 1'b1;
            end
            ST_OUT_COL: begin
                mac_ctl = '{enable: 1'b1, start: 1'b0};
                mac_a   = $signed({2'b00, col_reg});
                mac_b   = $signed({16'd0, px_bytes});
            end
            default: ;
        endcase
    end

    // Control state: sequencer, walk position, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_xfer && s_restart) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (load_out) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Intermediate results and descriptor payload
    always_ff @(posedge aclk) begin
        if (capture_stride) begin
            stride_reg <= mac_acc[19:0];
        end
        if (capture_in_addr) begin
            in_addr_reg <= mac_acc;
        end
        if (load_out) begin
            in_address_reg    <= err ? '0 : in_addr_reg;
            in_width_reg      <= err ? '0 : in_w_sum[15:0];
            in_height_reg     <= err ? '0 : in_h_sum[15:0];
            out_address_reg   <= err ? '0 : mac_acc;
            out_width_reg     <= err ? '0 : out_w[14:0];
            out_height_reg    <= err ? '0 : out_h[14:0];
            stride_out_reg    <= err ? '0 : stride_reg[18:0];
            offset_x_reg      <= err ? '0 : offx[14:0];
            offset_y_reg      <= err ? '0 : offy[14:0];
            last_tile_reg     <= last;
            setting_error_reg <= err;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_in_address       = in_address_reg;
    assign m_in_width         = in_width_reg;
    assign m_in_height        = in_height_reg;
    assign m_out_address      = out_address_reg;
    assign m_out_width        = out_width_reg;
    assign m_out_height       = out_height_reg;
    assign m_row_stride_bytes = stride_out_reg;
    assign m_offset_x         = offset_x_reg;
    assign m_offset_y         = offset_y_reg;
    assign m_last_tile        = last_tile_reg;
    assign m_setting_error    = setting_error_reg;

    // A finished descriptor waits while the previous one is still pending
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("descriptor left the sequencer while the output was occupied");

    // No second request is taken straight after a transfer
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_ready)
        else $error("request accepted while a descriptor is in progress");

    // An errored descriptor carries no addresses or sizes
    a_error_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && setting_error_reg) |->
            (in_address_reg == '0 && out_address_reg == '0 && out_width_reg == '0))
        else $error("errored descriptor carries non-zero fields");

    // The walk wraps to the first tile after the last one
    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && last) |=> (col_reg == 15'd0 && row_reg == 15'd0))
        else $error("walk did not wrap after the last tile");

endmodule

>>> hdl/otdg_regs.sv
// Configuration register file of the tile descriptor generator.
// Clamps dimensions to the limit and forces zero tile sizes to one.
// Depends on otdg_pkg.
module otdg_regs
    import otdg_pkg::*;
#(
    parameter int ADDRESS_BITS    = 48,
    parameter int DIMENSION_LIMIT = 16384
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  logic [CFG_INDEX_W-1:0]  wr_index,
    input  logic [ADDRESS_BITS-1:0] wr_data,
    output logic [ADDRESS_BITS-1:0] input_base,
    output logic [ADDRESS_BITS-1:0] output_base,
    output otdg_geom_t              geom
);

    localparam logic [15:0] DIM_MAX = 16'(DIMENSION_LIMIT);

    logic [ADDRESS_BITS-1:0] input_base_reg;
    logic [ADDRESS_BITS-1:0] output_base_reg;
    logic [14:0]             image_width_reg;
    logic [14:0]             image_height_reg;
    logic [2:0]              pixel_format_reg;
    logic [14:0]             overlap_pixels_reg;
    logic [14:0]             tile_width_reg;
    logic [14:0]             tile_height_reg;

    logic [15:0] tile_w_sat;
    logic [15:0] tile_h_sat;

    function automatic logic [15:0] sat_dim(input logic [14:0] v);
        return ({1'b0, v} > DIM_MAX) ? DIM_MAX : {1'b0, v};
    endfunction

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_base_reg     <= '0;
            output_base_reg    <= '0;
            image_width_reg    <= 15'd1024;
            image_height_reg   <= 15'd1024;
            pixel_format_reg   <= FMT_FLOAT4;
            overlap_pixels_reg <= 15'd64;
            tile_width_reg     <= 15'd256;
            tile_height_reg    <= 15'd256;
        end else if (wr_en) begin
            case (wr_index)
                REG_INPUT_BASE:     input_base_reg     <= wr_data;
                REG_OUTPUT_BASE:    output_base_reg    <= wr_data;
                REG_IMAGE_WIDTH:    image_width_reg    <= wr_data[14:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= wr_data[14:0];
                REG_PIXEL_FORMAT:   pixel_format_reg   <= wr_data[2:0];
                REG_OVERLAP_PIXELS: overlap_pixels_reg <= wr_data[14:0];
                REG_TILE_WIDTH:     tile_width_reg     <= wr_data[14:0];
                REG_TILE_HEIGHT:    tile_height_reg    <= wr_data[14:0];
                default: ;
            endcase
        end
    end

    // Clamped view
    assign tile_w_sat = sat_dim(tile_width_reg);
    assign tile_h_sat = sat_dim(tile_height_reg);

    assign input_base   = input_base_reg;
    assign output_base  = output_base_reg;
    assign geom.image_w = sat_dim(image_width_reg);
    assign geom.image_h = sat_dim(image_height_reg);
    assign geom.overlap = sat_dim(overlap_pixels_reg);
    assign geom.tile_w  = (tile_w_sat == 16'd0) ? 16'd1 : tile_w_sat;
    assign geom.tile_h  = (tile_h_sat == 16'd0) ? 16'd1 : tile_h_sat;
    assign geom.format  = pixel_format_reg;

endmodule

>>> hdl/otdg_mac.sv
// Shared multiply-accumulate unit: acc = (start ? base : acc) + a * b, modulo 2^ADDRESS_BITS.
// Operands are signed so that a negative region origin wraps as the address arithmetic expects.
// Depends on otdg_pkg.
module otdg_mac
    import otdg_pkg::*;
#(
    parameter int ADDRESS_BITS = 48
) (
    input  logic                     aclk,
    input  otdg_mac_ctl_t            ctl,
    input  logic signed [OP_A_W-1:0] op_a,
    input  logic signed [OP_B_W-1:0] op_b,
    input  logic [ADDRESS_BITS-1:0]  base,
    output logic [ADDRESS_BITS-1:0]  acc
);

    localparam int PROD_W = OP_A_W + OP_B_W;
    localparam int SUM_W  = (ADDRESS_BITS > PROD_W) ? ADDRESS_BITS : PROD_W;

    logic signed [PROD_W-1:0] prod;
    logic [SUM_W-1:0]         prod_ext;
    logic [SUM_W-1:0]         addend;
    logic [SUM_W-1:0]         sum;
    logic [ADDRESS_BITS-1:0]  acc_reg;
    logic [ADDRESS_BITS-1:0]  acc_next;

    // Product, sign-extended, plus either the base or the running sum
    assign prod     = op_a * op_b;
    assign prod_ext = SUM_W'(prod);
    assign addend   = SUM_W'(ctl.start ? base : acc_reg);
    assign sum      = prod_ext + addend;
    assign acc_next = sum[ADDRESS_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (ctl.enable) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
